// ===== hw/rtl/prct_pkg.sv =====
// ----------------------------------------------------------------------------
// prct_pkg: shared types and constants of the page reference count table
// Sizes of the cell row, request and status codes, and the command that the
// controller broadcasts to every cell.
// ----------------------------------------------------------------------------
package prct_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int PAGE_W      = 16;
  localparam int REF_W       = 8;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int GROUP_SIZE  = 32;
  localparam int NUM_GROUPS  = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD_DEPTH   = NUM_GROUPS * GROUP_SIZE;

  localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};
  localparam logic [REF_W-1:0] REF_ONE = REF_W'(1);

  typedef enum logic [1:0] {
    MODE_SHARE = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_INC   = 2'd2,
    MODE_DEC   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ALREADY    = 3'd1,
    ST_NOT_SHARED = 3'd2,
    ST_OVERFLOW   = 3'd3,
    ST_UNDERFLOW  = 3'd4,
    ST_FULL       = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_INSERT = 2'd1,
    OP_UPDATE = 2'd2,
    OP_DELETE = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [REF_W-1:0]  refs;
  } entry_t;

  // Broadcast to all cells: the operation, the requested page and the
  // count to write (1 on insert, the new count on update).
  typedef struct packed {
    cell_op_t          op;
    logic [PAGE_W-1:0] page;
    logic [REF_W-1:0]  refs;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/prct_cell.sv =====
// ----------------------------------------------------------------------------
// prct_cell: one entry of the sorted table
// Holds a page number and its count, compares against the request, and on a
// command takes the new entry or shifts with its left or right neighbor.
// ----------------------------------------------------------------------------
module prct_cell
  import prct_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occupied,
  input  logic      ge_left,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  output entry_t    entry,
  output logic      ge,
  output logic      eq
);

  entry_t entry_next;

  // Occupied cells are sorted and packed at the low end, so ge is monotone
  // along the row and its first set cell is the insert or match position.
  assign ge = !occupied || (entry.page >= cmd.page);
  assign eq = occupied && (entry.page == cmd.page);

  always_comb begin
    entry_next = entry;
    unique case (cmd.op)
      OP_NOP: begin
      end
      OP_INSERT: begin
        if (ge && !ge_left) begin
          entry_next = '{page: cmd.page, refs: cmd.refs};
        end else if (ge) begin
          entry_next = left_entry;
        end
      end
      OP_UPDATE: begin
        if (eq) begin
          entry_next.refs = cmd.refs;
        end
      end
      OP_DELETE: begin
        if (ge) begin
          entry_next = right_entry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== hw/rtl/prct_reduce.sv =====
// ----------------------------------------------------------------------------
// prct_reduce: registered match reduction over one group of cells
// At most one cell matches, so the count is gathered by an AND-OR select.
// ----------------------------------------------------------------------------
module prct_reduce
  import prct_pkg::*;
(
  input  logic                              clk,
  input  logic [GROUP_SIZE-1:0]             hit,
  input  logic [GROUP_SIZE-1:0][REF_W-1:0]  refs,
  output logic                              any_hit,
  output logic [REF_W-1:0]                  hit_refs
);

  logic [REF_W-1:0] refs_or;

  always_comb begin
    refs_or = '0;
    for (int k = 0; k < GROUP_SIZE; k++) begin
      refs_or = refs_or | (refs[k] & {REF_W{hit[k]}});
    end
  end

  always_ff @(posedge clk) begin
    any_hit  <= |hit;
    hit_refs <= refs_or;
  end

endmodule

// ===== hw/rtl/page_reference_count_table.sv =====
// ----------------------------------------------------------------------------
// page_reference_count_table: sorted table of shared pages with counts
// A row of cells keeps the shared pages in ascending order with an 8-bit
// reference count each; requests share, query, increment or decrement.
// ----------------------------------------------------------------------------
// Usage. A request transfer takes place at a rising edge where start is high
// and busy is low; mode and page_number are sampled at that edge. The block
// then raises busy while it steps through its group, merge and execute
// states, and returns exactly one result: done is high for one cycle
// together with was_shared, ref_count, page_freed and status, and that
// cycle's closing edge is the result transfer. The receiver cannot hold
// results off, so there is no stall path. busy is low again during the
// done cycle, so the next request can be taken at the same edge as the
// result transfer; a new request is never taken while one is in flight.
// The match search works in steps: every cell compares at once, a
// registered reduction over groups of 32 cells and a second registered
// stage over the groups find the matching count, and the execute state
// decides the action and lets all cells shift or update together.
// Reset (synchronous, active high) empties the table by clearing the entry
// count; cell contents are not cleared, since cells above the count are
// never consulted. Failed requests report an error status and leave the
// table unchanged.
// ----------------------------------------------------------------------------
module page_reference_count_table
  import prct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode,
  input  logic [PAGE_W-1:0] page_number,
  output logic              done,
  output logic              was_shared,
  output logic [REF_W-1:0]  ref_count,
  output logic              page_freed,
  output logic [2:0]        status
);

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_GROUP  = 4'b0010,
    S_MERGE  = 4'b0100,
    S_EXEC   = 4'b1000
  } state_t;

  state_t state, state_next;

  // Request registers, loaded on the request transfer.
  mode_t             req_mode;
  logic [PAGE_W-1:0] req_page;

  // Number of occupied cells; cells [0, entry_count) hold sorted entries.
  logic [CNT_W-1:0] entry_count, entry_count_next;

  // Cell row signals, padded to a whole number of reduction groups.
  entry_t                          cell_entry [TABLE_DEPTH];
  logic   [TABLE_DEPTH-1:0]        cell_ge;
  logic   [TABLE_DEPTH-1:0]        cell_eq;
  logic   [TABLE_DEPTH-1:0]        cell_occ;
  logic   [PAD_DEPTH-1:0]          pad_eq;
  logic   [PAD_DEPTH-1:0][REF_W-1:0] pad_refs;

  // Reduction results.
  logic [NUM_GROUPS-1:0]            grp_hit;
  logic [NUM_GROUPS-1:0][REF_W-1:0] grp_refs;
  logic                             found;
  logic [REF_W-1:0]                 found_refs;
  logic [REF_W-1:0]                 merge_refs;

  // Decision in the execute cycle.
  cell_cmd_t        cmd;
  cell_op_t         exec_op;
  logic [REF_W-1:0] exec_refs;
  status_t          exec_status;
  logic             exec_freed;

  logic accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_GROUP;
      S_GROUP: state_next = S_MERGE;
      S_MERGE: state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      done        <= (state == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode <= mode_t'(mode);
      req_page <= page_number;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row. Every cell sees the request page; neighbors pass entries left
  // and right for deletes and inserts, and the ge flag flows rightward so a
  // cell can tell whether it is the first at or above the requested page.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic   ge_left;
    entry_t left_entry;
    entry_t right_entry;

    assign cell_occ[i] = (IDX < entry_count);

    if (i == 0) begin : g_first
      assign ge_left    = 1'b0;
      assign left_entry = '{page: req_page, refs: REF_ONE};
    end else begin : g_inner_l
      assign ge_left    = cell_ge[i-1];
      assign left_entry = cell_entry[i-1];
    end

    // The last cell leaves the occupied range on a delete, so what it takes
    // from the right does not matter.
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_inner_r
      assign right_entry = cell_entry[i+1];
    end

    prct_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (cell_occ[i]),
      .ge_left     (ge_left),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .ge          (cell_ge[i]),
      .eq          (cell_eq[i])
    );
  end

  for (genvar i = 0; i < PAD_DEPTH; i++) begin : g_pad
    if (i < TABLE_DEPTH) begin : g_real
      assign pad_eq[i]   = cell_eq[i];
      assign pad_refs[i] = cell_entry[i].refs;
    end else begin : g_fill
      assign pad_eq[i]   = 1'b0;
      assign pad_refs[i] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Match search: first registered stage per group of cells, then a second
  // registered stage across the groups.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
    prct_reduce u_reduce (
      .clk      (clk),
      .hit      (pad_eq[g*GROUP_SIZE +: GROUP_SIZE]),
      .refs     (pad_refs[g*GROUP_SIZE +: GROUP_SIZE]),
      .any_hit  (grp_hit[g]),
      .hit_refs (grp_refs[g])
    );
  end

  always_comb begin
    merge_refs = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      merge_refs = merge_refs | (grp_refs[g] & {REF_W{grp_hit[g]}});
    end
  end

  always_ff @(posedge clk) begin
    found      <= |grp_hit;
    found_refs <= merge_refs;
  end

  // ---------------------------------------------------------------------------
  // Execute: choose the cell operation, the reported count and the status.
  // A missing page reads as count zero because the match select gives zero.
  // ---------------------------------------------------------------------------
  always_comb begin
    exec_op          = OP_NOP;
    exec_refs        = found_refs;
    exec_status      = ST_OK;
    exec_freed       = 1'b0;
    entry_count_next = entry_count;
    unique case (req_mode)
      MODE_SHARE: begin
        if (found) begin
          exec_status = ST_ALREADY;
        end else if (entry_count == CNT_W'(TABLE_DEPTH)) begin
          exec_status = ST_FULL;
        end else begin
          exec_op          = OP_INSERT;
          exec_refs        = REF_ONE;
          entry_count_next = entry_count + CNT_W'(1);
        end
      end
      MODE_QUERY: begin
      end
      MODE_INC: begin
        if (!found) begin
          exec_status = ST_NOT_SHARED;
        end else if (found_refs == REF_MAX) begin
          exec_status = ST_OVERFLOW;
        end else begin
          exec_op   = OP_UPDATE;
          exec_refs = found_refs + REF_ONE;
        end
      end
      MODE_DEC: begin
        if (!found) begin
          exec_status = ST_NOT_SHARED;
        end else if (found_refs == '0) begin
          exec_status = ST_UNDERFLOW;
        end else begin
          exec_refs = found_refs - REF_ONE;
          if (found_refs == REF_ONE) begin
            exec_op          = OP_DELETE;
            exec_freed       = 1'b1;
            entry_count_next = entry_count - CNT_W'(1);
          end else begin
            exec_op = OP_UPDATE;
          end
        end
      end
      default: begin
      end
    endcase
    if (state != S_EXEC) begin
      exec_op          = OP_NOP;
      entry_count_next = entry_count;
    end
  end

  assign cmd = '{op: exec_op, page: req_page, refs: exec_refs};

  // Result registers, shown while done is high.
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      was_shared <= found;
      ref_count  <= exec_refs;
      page_freed <= exec_freed;
      status     <= exec_status;
    end
  end

endmodule

// ===== sim/page_reference_count_table_tb.sv =====
// ----------------------------------------------------------------------------
// page_reference_count_table_tb: self-checking bench for the page table
// Drives share, query, increment and decrement requests through the start /
// busy handshake. The bench predicts every result from its own shadow of the
// table and compares each done strobe field by field with the oldest
// prediction. The stimulus runs in phases: directed corner cases, a counter
// walk to overflow and back, random traffic, and a fill to a full table.
// ----------------------------------------------------------------------------
module page_reference_count_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prct_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_CHUNKS  = 10;
  localparam int CHUNK_ITEMS    = 30;
  localparam int HOT_PAGES      = 40;

  // One request as the driver puts it on the ports.
  typedef struct {
    mode_t             op;
    logic [PAGE_W-1:0] page;
  } page_request_t;

  // One result as the block should report it.
  typedef struct {
    logic             was_shared;
    logic [REF_W-1:0] ref_count;
    logic             page_freed;
    status_t          status;
  } page_reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        mode = '0;
  logic [PAGE_W-1:0] page_number = '0;
  logic              busy;
  logic              done;
  logic              was_shared;
  logic [REF_W-1:0]  ref_count;
  logic              page_freed;
  logic [2:0]        status;

  page_request_t pending_requests[$];
  page_reply_t   predicted_replies[$];

  // Shadow of the table: reference count per shared page. Only the set of
  // pages and their counts matter for the results; the sort order inside the
  // block is invisible from the ports except through the full check.
  logic [REF_W-1:0] share_count [bit [PAGE_W-1:0]];

  int err_count    = 0;
  int replies_seen = 0;
  int idle_cycles  = 0;
  int gap_left     = 0;
  bit req_taken    = 1'b0;
  bit idle_on      = 1'b1;

  page_reference_count_table u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .page_number (page_number),
    .done        (done),
    .was_shared  (was_shared),
    .ref_count   (ref_count),
    .page_freed  (page_freed),
    .status      (status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Applies one accepted request to the shadow table and returns the result
  // the block must produce for it. Failed requests leave the shadow as is.
  function automatic page_reply_t apply_request(mode_t op, logic [PAGE_W-1:0] pg);
    page_reply_t      r;
    logic             hit;
    logic [REF_W-1:0] cnt;
    hit          = share_count.exists(pg);
    cnt          = hit ? share_count[pg] : '0;
    r.page_freed = 1'b0;
    r.status     = ST_OK;
    case (op)
      MODE_SHARE: begin
        if (hit) begin
          r.status = ST_ALREADY;
        end else if (share_count.num() >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          cnt             = REF_ONE;
          share_count[pg] = cnt;
        end
      end
      MODE_QUERY: begin
      end
      MODE_INC: begin
        if (!hit) begin
          r.status = ST_NOT_SHARED;
        end else if (cnt == REF_MAX) begin
          r.status = ST_OVERFLOW;
        end else begin
          cnt             = cnt + REF_ONE;
          share_count[pg] = cnt;
        end
      end
      default: begin
        // A stored count of zero would be an underflow, but no request
        // sequence can leave such an entry, so that branch stays dormant.
        if (!hit) begin
          r.status = ST_NOT_SHARED;
        end else if (cnt == '0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          cnt = cnt - REF_ONE;
          if (cnt == '0) begin
            share_count.delete(pg);
            r.page_freed = 1'b1;
          end else begin
            share_count[pg] = cnt;
          end
        end
      end
    endcase
    r.was_shared = hit;
    r.ref_count  = cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH result %0d %s: got %0d, expected %0d", replies_seen, what, got, want);
    err_count++;
  endtask

  task automatic push_req(input mode_t op, input logic [PAGE_W-1:0] pg);
    page_request_t req;
    req.op   = op;
    req.page = pg;
    pending_requests.push_back(req);
  endtask

  // Sender gaps: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Blocks until every queued request has been sent and every predicted
  // result has come back. Sampled at the rising edge, where the queue of
  // requests and start are stable; a result popped in the same step at worst
  // prolongs the wait.
  task automatic wait_idle();
    while (pending_requests.size() != 0 || start || predicted_replies.size() != 0)
      @(posedge clk);
  endtask

  // Driver: inputs change on the falling edge. A request stays on the ports
  // until the rising edge where it is taken; then the next one follows at
  // once or after a random gap. start gets at most one assignment per step.
  always @(negedge clk) begin
    page_request_t req;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      // Hold the request until busy lets it through.
    end else if (gap_left > 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_requests.size() != 0) begin
      req         = pending_requests.pop_front();
      start       <= 1'b1;
      mode        <= req.op;
      page_number <= req.page;
      gap_left    <= pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor and predictor: both sides are sampled on the rising edge. The
  // request transfer feeds the shadow table before the result of this edge
  // is checked, so an expectation is always queued ahead of its result.
  always @(posedge clk) begin
    page_reply_t want;
    req_taken = start && !busy && !rst;
    if (req_taken)
      predicted_replies.push_back(apply_request(mode_t'(mode), page_number));
    if (done && !rst) begin
      replies_seen++;
      if (predicted_replies.size() == 0) begin
        report_mismatch("arrived with no request waiting, status", status, -1);
      end else begin
        want = predicted_replies.pop_front();
        if (was_shared !== want.was_shared)
          report_mismatch("was_shared", was_shared, want.was_shared);
        if (ref_count !== want.ref_count)
          report_mismatch("ref_count", ref_count, want.ref_count);
        if (page_freed !== want.page_freed)
          report_mismatch("page_freed", page_freed, want.page_freed);
        if (status !== want.status)
          report_mismatch("status", status, want.status);
      end
    end
    // The watchdog restarts on any transfer in either direction.
    if (req_taken || (done && !rst))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    bit [PAGE_W-1:0]   used_page [bit [PAGE_W-1:0]];
    logic [PAGE_W-1:0] hot_page [HOT_PAGES];
    logic [PAGE_W-1:0] pg;
    logic [PAGE_W-1:0] fresh_page;
    int                roll;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corner cases: an empty table, the extreme page numbers, each
    // mode, already shared, not shared, and a decrement that frees a page.
    push_req(MODE_QUERY, 16'h0000);
    push_req(MODE_INC,   16'h1234);
    push_req(MODE_DEC,   16'hFFFF);
    push_req(MODE_SHARE, 16'h0000);
    push_req(MODE_SHARE, 16'hFFFF);
    push_req(MODE_SHARE, 16'h8000);
    push_req(MODE_SHARE, 16'h0000);
    push_req(MODE_QUERY, 16'hFFFF);
    push_req(MODE_INC,   16'hFFFF);
    push_req(MODE_QUERY, 16'hFFFF);
    push_req(MODE_DEC,   16'hFFFF);
    push_req(MODE_DEC,   16'hFFFF);
    push_req(MODE_DEC,   16'hFFFF);
    push_req(MODE_QUERY, 16'hFFFF);
    push_req(MODE_SHARE, 16'h7FFF);
    push_req(MODE_SHARE, 16'h5555);
    push_req(MODE_SHARE, 16'hAAAA);
    push_req(MODE_DEC,   16'h0000);
    push_req(MODE_DEC,   16'h8000);
    push_req(MODE_DEC,   16'h7FFF);
    push_req(MODE_DEC,   16'h5555);
    push_req(MODE_DEC,   16'hAAAA);
    push_req(MODE_QUERY, 16'h0000);
    wait_idle();

    // Walk one counter all the way to its ceiling, push past it, and come
    // back down until the page is freed.
    idle_on = 1'b0;
    push_req(MODE_SHARE, 16'h00FF);
    repeat (int'(REF_MAX) - 1) push_req(MODE_INC, 16'h00FF);
    push_req(MODE_INC,   16'h00FF);
    push_req(MODE_INC,   16'h00FF);
    push_req(MODE_QUERY, 16'h00FF);
    push_req(MODE_SHARE, 16'h00FF);
    idle_on = 1'b1;
    wait_idle();
    repeat (int'(REF_MAX)) push_req(MODE_DEC, 16'h00FF);
    push_req(MODE_DEC, 16'h00FF);
    wait_idle();

    // Random traffic. Most requests land on a small pool of pages so that
    // shares, increments and decrements meet existing entries; the rest use
    // any page number. Some chunks run without gaps, and the sender stops
    // twice until every outstanding result has come back.
    hot_page[0] = 16'h0000;
    hot_page[1] = 16'hFFFF;
    for (int i = 2; i < HOT_PAGES; i++) hot_page[i] = PAGE_W'($urandom_range(0, 16'hFFFF));
    for (int c = 0; c < RANDOM_CHUNKS; c++) begin
      idle_on = (c % 3) != 1;
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        if ($urandom_range(0, 9) == 0)
          pg = PAGE_W'($urandom_range(0, 16'hFFFF));
        else
          pg = hot_page[$urandom_range(0, HOT_PAGES - 1)];
        roll = $urandom_range(0, 99);
        if (roll < 30)      push_req(MODE_SHARE, pg);
        else if (roll < 45) push_req(MODE_QUERY, pg);
        else if (roll < 75) push_req(MODE_INC, pg);
        else                push_req(MODE_DEC, pg);
      end
      if (c == 3 || c == 7) wait_idle();
    end
    idle_on = 1'b1;
    wait_idle();

    // Fill the table with distinct pages in random order so that inserts
    // land all over the sorted row, then probe the full table.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      do pg = PAGE_W'($urandom_range(0, 16'hFFFF)); while (used_page.exists(pg));
      used_page[pg] = pg;
      push_req(MODE_SHARE, pg);
    end
    do fresh_page = PAGE_W'($urandom_range(0, 16'hFFFF));
    while (used_page.exists(fresh_page) || share_count.exists(fresh_page));
    push_req(MODE_SHARE, fresh_page);
    push_req(MODE_SHARE, pg);
    push_req(MODE_QUERY, pg);
    push_req(MODE_INC,   pg);
    push_req(MODE_QUERY, fresh_page);
    wait_idle();
    // Free one slot, reuse it, and hit the limit once more.
    foreach (used_page[k]) begin
      if (k != pg) begin
        push_req(MODE_DEC, k);
        break;
      end
    end
    push_req(MODE_SHARE, fresh_page);
    do fresh_page = PAGE_W'($urandom_range(0, 16'hFFFF));
    while (used_page.exists(fresh_page) || share_count.exists(fresh_page));
    push_req(MODE_SHARE, fresh_page);

    wait_idle();
    repeat (8) @(posedge clk);
    if (predicted_replies.size() != 0)
      report_mismatch("results never returned, count", predicted_replies.size(), 0);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== page_reference_count_table.f =====
hw/rtl/prct_pkg.sv
hw/rtl/prct_cell.sv
hw/rtl/prct_reduce.sv
hw/rtl/page_reference_count_table.sv
sim/page_reference_count_table_tb.sv
